// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

// a in this cycle implies c in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/rtsn_pkg.sv =====
// Shared types and constants for the row top-k sparsifier
package rtsn_pkg;

  localparam int MaxRow  = 64;
  localparam int ColW    = $clog2(MaxRow);
  localparam int CntW    = ColW + 1;
  localparam int ValW    = 16;
  localparam int SumW    = ValW + ColW;
  localparam int QW      = ValW + 1;
  localparam int NumW    = 2 * ValW + 1;
  localparam int DivCntW = $clog2(QW);

  localparam logic CFG_K   = 1'b0;
  localparam logic CFG_LEN = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [ValW-1:0] value;
    logic [ColW-1:0] col;
  } cell_data_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_READ,
    S_CALC,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ===== src/rtsn_ram.sv =====
// Generic single-write, single-read RAM with registered read
module rtsn_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/rtsn_cell.sv =====
// One cell of the sorted insertion chain
module rtsn_cell (
  input  logic                clk,
  input  logic                rst,
  input  rtsn_pkg::cell_ctrl_t ctrl,
  input  rtsn_pkg::cell_data_t new_data,
  input  rtsn_pkg::cell_data_t prev_data,
  input  logic                prev_take,
  input  rtsn_pkg::cell_data_t next_data,
  output rtsn_pkg::cell_data_t data,
  output logic                take
);
  import rtsn_pkg::*;

  assign take = ctrl.ins && (!data.valid || new_data.value > data.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
    end else if (ctrl.pop) begin
      data <= next_data;
    end else if (take) begin
      data <= prev_take ? prev_data : new_data;
    end
  end
endmodule

// ===== src/rtsn_div.sv =====
// Restoring divider, one quotient bit per cycle
module rtsn_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rtsn_pkg::NumW-1:0] num,
  input  logic [rtsn_pkg::SumW-1:0] den,
  output logic                     done,
  output logic [rtsn_pkg::QW-1:0]   quot
);
  import rtsn_pkg::*;

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [SumW-1:0]    rem;
  logic [SumW:0]      sh;
  logic [SumW:0]      diff;
  logic               ge;

  assign sh   = {rem, quot[QW-1]};
  assign diff = sh - {1'b0, den};
  assign ge   = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= SumW'(num[NumW-1:QW]);
        quot <= num[QW-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[SumW-1:0] : sh[SumW-1:0];
        quot <= {quot[QW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == DivCntW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/row_top_k_sparsify_normalize.sv =====
// Top level: row top-k selection and normalization
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------
//  input    | in_valid / in_ready  | sim_value
//  output   | out_valid / out_ready| weight, column, row_last
//  config   | cfg_we               | cfg_index, cfg_data
//
// Values enter one per cycle while a row fills; the insertion chain sorts as they arrive.
// At row end the chain drains; then each column goes through RAM read, setup and output,
// with a kept column also passing through the 17-step divider when the kept sum is nonzero;
// output can wait on out_ready.
// Input is held off from row end until the last column transaction.
// Synchronous reset clears control, the chain and the kept mask.
module row_top_k_sparsify_normalize (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rtsn_pkg::ValW-1:0]   sim_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rtsn_pkg::ValW-1:0]   weight,
  output logic [rtsn_pkg::ColW-1:0]   column,
  output logic                        row_last,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rtsn_pkg::CntW-1:0]   cfg_data
);
  import rtsn_pkg::*;
  `include "assert_macros.svh"

  state_t            state, state_next;
  logic [CntW-1:0]   k_neighbors;
  logic [CntW-1:0]   row_length;
  logic [CntW-1:0]   len_eff;
  logic [CntW-1:0]   column_count;
  logic [CntW-1:0]   count_plus;
  logic [CntW-1:0]   kept_cnt;
  logic [SumW-1:0]   sum;
  logic [MaxRow-1:0] kept_mask;
  logic [ColW-1:0]   out_col;
  logic [ValW-1:0]   rdata;
  logic              in_acc;
  logic              keep_head;
  logic              div_start;
  logic              div_done;
  logic [QW-1:0]     quot;
  logic [NumW-1:0]   num;

  cell_ctrl_t        ctrl;
  cell_data_t        new_data;
  cell_data_t        cdata [MaxRow];
  logic [MaxRow-1:0] take;

  always_comb begin
    len_eff = row_length;
    if (row_length == '0) begin
      len_eff = CntW'(1);
    end else if (row_length > CntW'(MaxRow)) begin
      len_eff = CntW'(MaxRow);
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign count_plus = column_count + 1'b1;
  assign out_valid  = (state == S_OUT);
  assign column     = out_col;
  assign row_last   = (CntW'(out_col) == len_eff - 1'b1);

  assign ctrl.ins       = in_acc;
  assign ctrl.pop       = (state == S_POP);
  assign new_data.valid = 1'b1;
  assign new_data.value = sim_value;
  assign new_data.col   = column_count[ColW-1:0];

  for (genvar i = 0; i < MaxRow; i++) begin : g_chain
    cell_data_t prev_d, next_d;
    logic       prev_t;
    if (i == 0) begin : g_head
      assign prev_d = '0;
      assign prev_t = 1'b0;
    end else begin : g_mid
      assign prev_d = cdata[i-1];
      assign prev_t = take[i-1];
    end
    if (i == MaxRow - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_body
      assign next_d = cdata[i+1];
    end
    rtsn_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_data  (new_data),
      .prev_data (prev_d),
      .prev_take (prev_t),
      .next_data (next_d),
      .data      (cdata[i]),
      .take      (take[i])
    );
  end

  rtsn_ram #(.Width(ValW), .Depth(MaxRow)) u_row_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (column_count[ColW-1:0]),
    .wdata (sim_value),
    .raddr (out_col),
    .rdata (rdata)
  );

  assign num = NumW'({rdata, {ValW{1'b0}}}) + NumW'(sum[SumW-1:1]);

  rtsn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (sum),
    .done  (div_done),
    .quot  (quot)
  );

  assign keep_head = cdata[0].valid && (CntW'(cdata[0].col) < len_eff)
                     && (kept_cnt < k_neighbors);
  assign div_start = (state == S_CALC) && (sum != '0) && kept_mask[out_col];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && count_plus >= len_eff) state_next = S_POP;
      S_POP:  if (!cdata[0].valid) state_next = S_READ;
      S_READ: state_next = S_CALC;
      S_CALC: state_next = div_start ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = row_last ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_neighbors  <= CntW'(20);
      row_length   <= CntW'(32);
      column_count <= '0;
      kept_mask    <= '0;
      kept_cnt     <= '0;
      sum          <= '0;
      out_col      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_K) begin
          k_neighbors <= cfg_data;
        end else begin
          row_length <= cfg_data;
        end
      end
      if (in_acc) begin
        if (count_plus >= len_eff) begin
          column_count <= '0;
          kept_mask    <= '0;
          kept_cnt     <= '0;
          sum          <= '0;
          out_col      <= '0;
        end else begin
          column_count <= count_plus;
        end
      end
      if (state == S_POP && keep_head) begin
        sum                     <= sum + SumW'(cdata[0].value);
        kept_mask[cdata[0].col] <= 1'b1;
        kept_cnt                <= kept_cnt + 1'b1;
      end
      if (state == S_OUT && out_ready && !row_last) begin
        out_col <= out_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC && !div_start) begin
      weight <= '0;
    end else if (state == S_DIV && div_done) begin
      weight <= quot[QW-1] ? {ValW{1'b1}} : quot[ValW-1:0];
    end
  end

  `ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `ASSERT_NEXT(a_row_end_idle, clk, rst, out_valid && out_ready && row_last, in_ready)
  `ASSERT_NEVER(a_col_range, clk, rst, out_valid && (CntW'(column) >= len_eff))
  `ASSERT_NEVER(a_kept_bound, clk, rst, (state == S_POP) && (kept_cnt > k_neighbors))
endmodule

// ===== tb/row_top_k_sparsify_normalize_tb.sv =====
// Testbench for the row top-k sparsifier: directed and random rows checked against a scoreboard
`timescale 1ns / 100ps

class row_weight_board;
  int unsigned k_cfg;
  int unsigned len_cfg;
  logic [15:0] row_vals[64];
  int unsigned col_cnt;
  logic [15:0] exp_weight[$];
  logic [5:0]  exp_column[$];
  logic        exp_last[$];
  int          errors;

  function new();
    k_cfg   = 20;
    len_cfg = 32;
    col_cnt = 0;
    errors  = 0;
  endfunction

  function int unsigned row_len();
    int unsigned n;
    n = len_cfg & 7'h7f;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  function void note_value(logic [15:0] v);
    int unsigned n;
    int unsigned k;
    int unsigned best;
    bit found;
    bit kept[64];
    longint unsigned sum;
    longint unsigned w;
    n = row_len();
    if (col_cnt < 64) row_vals[col_cnt] = v;
    col_cnt = (col_cnt + 1) & 7'h7f;
    if (col_cnt < n) return;
    col_cnt = 0;
    k = k_cfg & 7'h7f;
    if (k > n) k = n;
    foreach (kept[i]) kept[i] = 0;
    for (int p = 0; p < k; p++) begin
      found = 0;
      best  = 0;
      for (int c = 0; c < n; c++) begin
        if (!kept[c] && (!found || row_vals[c] > row_vals[best])) begin
          best  = c;
          found = 1;
        end
      end
      if (found) kept[best] = 1;
    end
    sum = 0;
    for (int c = 0; c < n; c++) if (kept[c]) sum += row_vals[c];
    for (int c = 0; c < n; c++) begin
      w = 0;
      if (sum != 0 && kept[c]) begin
        w = ((longint'(row_vals[c]) << 16) + (sum >> 1)) / sum;
        if (w > 65535) w = 65535;
      end
      exp_weight.push_back(w[15:0]);
      exp_column.push_back(c[5:0]);
      exp_last.push_back(c + 1 == n);
    end
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task check(logic [15:0] w, logic [5:0] col, logic last);
    if (exp_weight.size() == 0) begin
      report("unexpected transaction", w, 0);
    end else begin
      if (w !== exp_weight[0]) report("weight", w, exp_weight[0]);
      if (col !== exp_column[0]) report("column", col, exp_column[0]);
      if (last !== exp_last[0]) report("row_last", last, exp_last[0]);
      void'(exp_weight.pop_front());
      void'(exp_column.pop_front());
      void'(exp_last.pop_front());
    end
  endtask

  function int pending();
    return exp_weight.size();
  endfunction
endclass

module row_top_k_sparsify_normalize_tb;
  import rtsn_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [ValW-1:0] sim_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [ValW-1:0] weight;
  logic [ColW-1:0] column;
  logic row_last;
  logic cfg_we = 0;
  logic cfg_index = CFG_K;
  logic [CntW-1:0] cfg_data = '0;

  row_weight_board board = new();
  bit calm = 0;
  int stall_cycles = 0;
  int sent = 0;

  row_top_k_sparsify_normalize dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check(weight, column, row_last);
      out_ready <= calm || ($urandom_range(99) >= 29);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val[CntW-1:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_K) board.k_cfg = val & 7'h7f;
    else board.len_cfg = val & 7'h7f;
    @(posedge clk);
  endtask

  task automatic send_value(logic [15:0] v);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid  <= 1;
    sim_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_value(v);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_value(int mode);
    case (mode)
      0: return 16'($urandom_range(3));
      1: return 16'(16'hffff - $urandom_range(2));
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_row(int n, int mode);
    for (int i = 0; i < n; i++) send_value(rand_value(mode));
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, ties, zero sum, zero k, large k, clamps
    write_reg(CFG_K, 2);
    write_reg(CFG_LEN, 4);
    send_value(16'hffff); send_value(16'h0000); send_value(16'hffff); send_value(16'h0001);
    send_row(4, 2);
    drain();
    write_reg(CFG_K, 3);
    send_row(4, 0);
    send_value(0); send_value(0); send_value(0); send_value(0);
    drain();
    write_reg(CFG_K, 0);
    send_row(4, 3);
    drain();
    write_reg(CFG_K, 100);
    write_reg(CFG_LEN, 0);
    send_value(16'h1234); send_value(0);
    drain();
    write_reg(CFG_LEN, 127);
    write_reg(CFG_K, 64);
    send_row(64, 1);
    drain();
    write_reg(CFG_K, 1);
    write_reg(CFG_LEN, 64);
    send_row(64, 3);
    drain();
    // random rows
    while (sent < 480) begin
      calm = (sent >= 300 && sent < 380);
      if ($urandom_range(3) == 0) begin
        drain();
        write_reg(CFG_K, $urandom_range(127));
        write_reg(CFG_LEN, ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(12));
      end
      n = board.row_len();
      send_row(n, $urandom_range(5));
    end
    calm = 0;
    drain();
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    @(negedge rst);
  end
endmodule
